// File: rtl/ssrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_pkg: shared types and constants of the soft-start ramp controller
// Transaction payloads, configuration record, mode and message codes, phase
// codes of the tick sequencer and the firing-angle constants.
// ----------------------------------------------------------------------------
package ssrc_pkg;

	// Firing angle range and thresholds
	localparam int          TOTAL_ANGLE    = 151;
	localparam logic [7:0]  ANGLE_TOTAL    = 8'(TOTAL_ANGLE);
	localparam logic [7:0]  ANGLE_MAX      = 8'(TOTAL_ANGLE - 1);
	localparam logic [7:0]  ANGLE_RESET    = 8'd150;
	localparam logic [7:0]  RISE_RESET     = 8'd172;
	localparam logic [7:0]  FALL_RESET     = 8'd178;
	localparam logic [7:0]  RISE_OFFSET    = 8'd20;
	localparam logic [7:0]  FALL_OFFSET    = 8'd28;
	localparam logic [7:0]  PDE_UP_ANGLE   = 8'd135;
	localparam logic [7:0]  PDE_DOWN_ANGLE = 8'd14;
	localparam logic [11:0] LOW_CURRENT_MA = 12'd50;

	// Configuration register reset values
	localparam logic [13:0] SHUTDOWN_RESET   = 14'd1000;
	localparam logic [9:0]  OVERCURRENT_RESET = 10'd655;
	localparam logic [15:0] UP_PERIOD_RESET   = 16'd661;
	localparam logic [15:0] DOWN_PERIOD_RESET = 16'd661;

	// Register port
	localparam int ADDR_W = 4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_SHUTDOWN    = 2'd0,
		REG_OVERCURRENT = 2'd1,
		REG_UP_PERIOD   = 2'd2,
		REG_DOWN_PERIOD = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_EMERG = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		MODE_START     = 3'd0,
		MODE_STOP      = 3'd1,
		MODE_EMERG     = 3'd2,
		MODE_IDLE_UP   = 3'd3,
		MODE_IDLE_DOWN = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		MSG_COP = 4'd0,
		MSG_SCL = 4'd1,
		MSG_CDD = 4'd2,
		MSG_EME = 4'd3,
		MSG_PDE = 4'd4,
		MSG_RDS = 4'd5,
		MSG_RDD = 4'd6,
		MSG_ON  = 4'd7,
		MSG_OFF = 4'd8
	} msg_t;

	// Sequencer phases, one per cycle while the output is not stalled
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TRIP    = 3'd1,
		PH_OC      = 3'd2,
		PH_EMERG   = 3'd3,
		PH_RAMP    = 3'd4,
		PH_END     = 3'd5,
		PH_STANDBY = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] current_ma;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  message_code;
		logic        pulses_enabled;
		logic [7:0]  rise_edge;
		logic [7:0]  fall_edge;
		logic        bypass_closed;
		logic [15:0] step_period;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [13:0] shutdown_current;
		logic [9:0]  overcurrent_limit;
		logic [15:0] up_step_period;
		logic [15:0] down_step_period;
	} cfg_t;

	// Classified item as queued for the back end
	typedef struct packed {
		logic  is_cmd;
		mode_t cmd_mode;
		logic  trip;
		logic  over;
		logic  low;
	} q_item_t;

	function automatic logic [7:0] rise_of(input logic [7:0] angle);
		return angle + RISE_OFFSET;
	endfunction

	function automatic logic [7:0] fall_of(input logic [7:0] angle);
		return angle + FALL_OFFSET;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ssrc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_queue: short queue of classified items
// Register FIFO between the front and back ends, so that each side stalls
// on its own.
// ----------------------------------------------------------------------------
module ssrc_queue
	import ssrc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push_valid,
	output logic         push_ready,
	input  wire q_item_t push_item,
	output logic         pop_valid,
	input  wire logic    pop_ready,
	output q_item_t      pop_item
);

	q_item_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ssrc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_front: register port and item classifier
// Holds the configuration registers and turns each accepted item into a
// command or a tick with its current comparisons already made.
// ----------------------------------------------------------------------------
module ssrc_front
	import ssrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// item channel
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire in_item_t          item,
	// to back end
	output cfg_t                   cfg,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output q_item_t                push_item
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shutdown_current  <= SHUTDOWN_RESET;
			cfg_q.overcurrent_limit <= OVERCURRENT_RESET;
			cfg_q.up_step_period    <= UP_PERIOD_RESET;
			cfg_q.down_step_period  <= DOWN_PERIOD_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SHUTDOWN:    cfg_q.shutdown_current  <= pwdata[13:0];
				REG_OVERCURRENT: cfg_q.overcurrent_limit <= pwdata[9:0];
				REG_UP_PERIOD:   cfg_q.up_step_period    <= pwdata[15:0];
				REG_DOWN_PERIOD: cfg_q.down_step_period  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_SHUTDOWN:    prdata = {18'd0, cfg_q.shutdown_current};
			REG_OVERCURRENT: prdata = {22'd0, cfg_q.overcurrent_limit};
			REG_UP_PERIOD:   prdata = {16'd0, cfg_q.up_step_period};
			REG_DOWN_PERIOD: prdata = {16'd0, cfg_q.down_step_period};
			default:         prdata = '0;
		endcase
	end

	// Classification: command target mode, or tick current comparisons
	always_comb begin
		push_item.is_cmd   = (action_t'(item.action) != ACT_TICK);
		push_item.trip     = ({2'b00, item.current_ma} >= cfg_q.shutdown_current);
		push_item.over     = (item.current_ma >= {2'b00, cfg_q.overcurrent_limit});
		push_item.low      = (item.current_ma < LOW_CURRENT_MA);
		case (action_t'(item.action))
			ACT_START: push_item.cmd_mode = MODE_START;
			ACT_STOP:  push_item.cmd_mode = MODE_STOP;
			ACT_EMERG: push_item.cmd_mode = MODE_EMERG;
			default:   push_item.cmd_mode = MODE_IDLE_UP;
		endcase
	end

	assign push_valid = item_valid;
	assign item_ready = push_ready;

endmodule
`default_nettype wire

// File: rtl/ssrc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrc_back: tick sequencer and result staging
// Applies commands and walks a tick through its checks, one phase and at
// most one message per cycle while the output is not stalled. A holding
// register keeps the newest message until it is known whether it ends the
// tick, then an output register presents it.
// ----------------------------------------------------------------------------
module ssrc_back
	import ssrc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    pop_valid,
	output logic         pop_ready,
	input  wire q_item_t pop_item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output out_item_t    result
);

	// Controller state
	mode_t       mode_q, mode_d;
	logic [7:0]  angle_q, angle_d;
	logic [7:0]  rise_q, rise_d;
	logic [7:0]  fall_q, fall_d;
	logic        pulse_q, pulse_d;
	logic        bypass_q, bypass_d;
	logic        pdown_q, pdown_d;
	phase_t      phase_q, phase_d;
	logic        over_q, low_q;

	// Staging
	logic        pend_v_q;
	out_item_t   pend_q;
	logic        out_v_q;
	out_item_t   out_q;

	logic        emit, finish, do_emerg, keep_edges;
	msg_t        msg;
	logic        step_go, out_free, pend_to_out, pop;
	out_item_t   new_msg;

	assign out_free    = !out_v_q || result_ready;
	assign step_go     = (phase_q != PH_IDLE) && (!emit || !pend_v_q || out_free);
	assign pend_to_out = pend_v_q && out_free && (pend_q.last || (step_go && emit));
	assign pop         = pop_valid && ((phase_q == PH_IDLE) || (step_go && finish));
	assign pop_ready   = pop;

	// Next state of one sequencer phase
	always_comb begin
		mode_d     = mode_q;
		angle_d    = angle_q;
		rise_d     = rise_q;
		fall_d     = fall_q;
		pulse_d    = pulse_q;
		bypass_d   = bypass_q;
		pdown_d    = pdown_q;
		phase_d    = phase_q;
		emit       = 1'b0;
		finish     = 1'b0;
		do_emerg   = 1'b0;
		keep_edges = 1'b0;
		msg        = MSG_COP;

		case (phase_q)
			PH_TRIP: begin
				do_emerg = 1'b1;
				msg      = MSG_CDD;
				phase_d  = PH_OC;
			end
			PH_OC: begin
				emit = 1'b1;
				if (over_q) begin
					msg    = MSG_SCL;
					finish = 1'b1;
				end else begin
					msg = MSG_COP;
					case (mode_q)
						MODE_EMERG:                    phase_d = PH_EMERG;
						MODE_START, MODE_STOP:         phase_d = PH_RAMP;
						MODE_IDLE_UP, MODE_IDLE_DOWN:  phase_d = PH_STANDBY;
						default:                       finish  = 1'b1;
					endcase
				end
			end
			PH_EMERG: begin
				do_emerg = 1'b1;
				msg      = MSG_EME;
				phase_d  = PH_STANDBY;
			end
			PH_RAMP: begin
				case (mode_q)
					MODE_START: begin
						if (angle_q <= PDE_UP_ANGLE && low_q) begin
							do_emerg = 1'b1;
							msg      = MSG_PDE;
							finish   = 1'b1;
						end else begin
							pulse_d    = 1'b1;
							pdown_d    = 1'b0;
							emit       = 1'b1;
							keep_edges = 1'b1;
							msg        = MSG_RDS;
							if (angle_q < ANGLE_TOTAL && angle_q != 8'd0) begin
								rise_d  = rise_of(angle_q);
								fall_d  = fall_of(angle_q);
								angle_d = angle_q - 8'd1;
								finish  = 1'b1;
							end else begin
								phase_d = PH_END;
							end
						end
					end
					MODE_STOP: begin
						if (angle_q >= PDE_DOWN_ANGLE && low_q) begin
							do_emerg = 1'b1;
							msg      = MSG_PDE;
							finish   = 1'b1;
						end else begin
							pulse_d    = 1'b1;
							bypass_d   = 1'b0;
							pdown_d    = 1'b1;
							emit       = 1'b1;
							keep_edges = 1'b1;
							msg        = MSG_RDD;
							if (angle_q < ANGLE_MAX) begin
								rise_d  = rise_of(angle_q);
								fall_d  = fall_of(angle_q);
								angle_d = angle_q + 8'd1;
								finish  = 1'b1;
							end else begin
								phase_d = PH_END;
							end
						end
					end
					default: finish = 1'b1;
				endcase
			end
			PH_END: begin
				phase_d = PH_STANDBY;
				case (mode_q)
					MODE_START: begin
						bypass_d = 1'b1;
						pulse_d  = 1'b0;
						emit     = 1'b1;
						msg      = MSG_ON;
						mode_d   = MODE_IDLE_UP;
					end
					MODE_STOP: begin
						emit   = 1'b1;
						msg    = MSG_OFF;
						mode_d = MODE_IDLE_DOWN;
					end
					default: finish = 1'b1;
				endcase
			end
			PH_STANDBY: begin
				finish = 1'b1;
				case (mode_q)
					MODE_IDLE_UP: begin
						if (angle_q <= PDE_UP_ANGLE && low_q) begin
							do_emerg = 1'b1;
							msg      = MSG_PDE;
						end
					end
					MODE_IDLE_DOWN: begin
						if (angle_q >= PDE_DOWN_ANGLE && low_q) begin
							do_emerg = 1'b1;
							msg      = MSG_PDE;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// Emergency measure: pulses off, angle to the top, standby after start
		if (do_emerg) begin
			emit    = 1'b1;
			pulse_d = 1'b0;
			angle_d = ANGLE_MAX;
			rise_d  = rise_of(ANGLE_MAX);
			fall_d  = fall_of(ANGLE_MAX);
			mode_d  = MODE_IDLE_UP;
		end
	end

	// Message snapshot; ramp messages go out before the edges move
	always_comb begin
		new_msg.message_code   = msg;
		new_msg.pulses_enabled = pulse_d;
		new_msg.rise_edge      = keep_edges ? rise_q : rise_d;
		new_msg.fall_edge      = keep_edges ? fall_q : fall_d;
		new_msg.bypass_closed  = bypass_d;
		new_msg.step_period    = pdown_d ? cfg.down_step_period : cfg.up_step_period;
		new_msg.last           = finish;
	end

	// Controller state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE_UP;
			angle_q  <= ANGLE_RESET;
			rise_q   <= RISE_RESET;
			fall_q   <= FALL_RESET;
			pulse_q  <= 1'b1;
			bypass_q <= 1'b0;
			pdown_q  <= 1'b0;
			phase_q  <= PH_IDLE;
			over_q   <= 1'b0;
			low_q    <= 1'b0;
		end else begin
			if (step_go) begin
				angle_q  <= angle_d;
				rise_q   <= rise_d;
				fall_q   <= fall_d;
				pulse_q  <= pulse_d;
				bypass_q <= bypass_d;
				pdown_q  <= pdown_d;
			end
			// next item; a command lands after any update of the tick before it
			if (pop && pop_item.is_cmd) begin
				mode_q <= pop_item.cmd_mode;
			end else if (step_go) begin
				mode_q <= mode_d;
			end
			if (pop) begin
				if (pop_item.is_cmd) begin
					phase_q <= PH_IDLE;
				end else begin
					phase_q <= pop_item.trip ? PH_TRIP : PH_OC;
				end
			end else if (step_go) begin
				phase_q <= finish ? PH_IDLE : phase_d;
			end
			if (pop && !pop_item.is_cmd) begin
				over_q <= pop_item.over;
				low_q  <= pop_item.low;
			end
		end
	end

	// Holding and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (step_go && emit) begin
				pend_v_q <= 1'b1;
			end else if (pend_to_out) begin
				pend_v_q <= 1'b0;
			end
			if (pend_to_out) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emit) begin
			pend_q <= new_msg;
		end else if (step_go && finish) begin
			pend_q.last <= 1'b1;
		end
		if (pend_to_out) begin
			out_q <= pend_q;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
`default_nettype wire

// File: rtl/soft_start_ramp_controller_unit.sv
// Path: a tick's first result passes the queue, a sequencer phase and the
// holding register before it is presented, and waits in the holding register
// while the next phase only closes the tick; receiver stalls delay it further.
// Throughput: one check phase a cycle with at most one message each, while
// the output is not stalled.
// Reset: arst_n restores register and controller reset values at once.
`default_nettype none
// ----------------------------------------------------------------------------
// soft_start_ramp_controller_unit: thyristor soft-starter sequencer
// Front end classifies items and holds configuration, a two-entry queue
// decouples it from the back end that runs the tick checks and ramp.
// ----------------------------------------------------------------------------
module soft_start_ramp_controller_unit
	import ssrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire in_item_t          item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output out_item_t              result
);

	cfg_t    cfg;
	logic    push_valid, push_ready;
	q_item_t push_item;
	logic    pop_valid, pop_ready;
	q_item_t pop_item;

	ssrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	ssrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	ssrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Overcurrent hold always ends the tick
	a_scl_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_code == MSG_SCL |-> result.last)
		else $error("SCL not marked last");

	// A shutdown trip is always followed by SCL or COP
	a_cdd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_code == MSG_CDD |-> !result.last)
		else $error("CDD marked last");

	// Ramp end closes the bypass with pulses off
	a_on_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_code == MSG_ON |->
			result.bypass_closed && !result.pulses_enabled)
		else $error("ON without bypass closed");

	// Ramp messages carry pulses on
	a_ramp_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.message_code == MSG_RDS || result.message_code == MSG_RDD)
			|-> result.pulses_enabled)
		else $error("ramp message with pulses off");

endmodule
`default_nettype wire
